### sv/ssr_pkg.sv
// shared types and constants for the stream segment reverser
// used by ssr_ctrl, ssr_datapath and stream_segment_reverser_top
package ssr_pkg;

	localparam int DATA_WIDTH  = 8;
	localparam int STACK_DEPTH = 63;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		MODE_BEFORE,
		MODE_INSIDE,
		MODE_AFTER
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_WR
	} state_t;

	typedef struct packed {
		logic push;         // store the incoming element on the stack
		logic load_pass;    // load the incoming element into the output register
		logic flush_start;  // capture the lost flag for the coming flush
		logic pop_rd;       // read top of stack, drop the count
		logic load_pop;     // load the popped element into the output register
		logic out_last;     // last flag for the loaded result
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_end;
		logic markers_equal;
		logic count_zero;
		logic out_free;
	} dp_status_t;

endpackage

### sv/ssr_datapath.sv
// datapath: marker registers, element stack memory, held count, output register
// depends on ssr_pkg
module ssr_datapath import ssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	input  logic [DATA_WIDTH-1:0] element_value,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic                  is_last_output,
	output logic                  overflow
);

	logic [DATA_WIDTH-1:0] start_marker_q;
	logic [DATA_WIDTH-1:0] end_marker_q;
	logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [CNT_W-1:0]      held_count_q;
	logic [CNT_W-1:0]      cnt_dec;
	logic                  lost_q;
	logic                  flush_ovf_q;
	logic                  stack_full;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	assign cfg_ready  = 1'b1;
	assign stack_full = (held_count_q == CNT_W'(STACK_DEPTH));
	assign cnt_dec    = held_count_q - CNT_W'(1);

	assign sts.is_start      = (element_value == start_marker_q);
	assign sts.is_end        = (element_value == end_marker_q);
	assign sts.markers_equal = (start_marker_q == end_marker_q);
	assign sts.count_zero    = (held_count_q == '0);
	assign sts.out_free      = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			end_marker_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			lost_q       <= 1'b0;
			flush_ovf_q  <= 1'b0;
		end else begin
			if (cmd.push && !stack_full) begin
				held_count_q <= held_count_q + CNT_W'(1);
			end else if (cmd.pop_rd) begin
				held_count_q <= cnt_dec;
			end
			// a flush reports any drop in its segment, including one this cycle
			if (cmd.flush_start) begin
				flush_ovf_q <= lost_q || (cmd.push && stack_full);
				lost_q      <= 1'b0;
			end else if (cmd.push && stack_full) begin
				lost_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !stack_full) begin
			stack_mem[held_count_q[ADDR_W-1:0]] <= element_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_rd) begin
			rd_data_q <= stack_mem[cnt_dec[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_pass || cmd.load_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pass) begin
			out_value_q <= element_value;
			out_last_q  <= cmd.out_last;
			out_ovf_q   <= 1'b0;
		end else if (cmd.load_pop) begin
			out_value_q <= rd_data_q;
			out_last_q  <= cmd.out_last;
			out_ovf_q   <= flush_ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_value      = out_value_q;
	assign is_last_output = out_last_q;
	assign overflow       = out_ovf_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(STACK_DEPTH))
		else $error("held count beyond stack depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> (held_count_q != '0))
		else $error("pop from an empty stack");
`endif

endmodule

### sv/ssr_ctrl.sv
// controller: segment mode and flush sequencer
// depends on ssr_pkg, drives ssr_datapath through ctrl_cmd_t
module ssr_ctrl import ssr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       is_last_input,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   seq_last_q, seq_last_d;
	logic   in_ready;
	logic   accept;
	logic   do_push;
	logic   do_pass;
	logic   do_flush;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign in_stall = !in_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_BEFORE;
			seq_last_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			seq_last_q <= seq_last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		seq_last_d = seq_last_q;
		cmd        = '0;
		do_push    = 1'b0;
		do_pass    = 1'b0;
		do_flush   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode_q)
						MODE_BEFORE: begin
							if (sts.is_start && sts.markers_equal) begin
								do_pass = 1'b1;
								mode_d  = MODE_AFTER;
							end else if (sts.is_start) begin
								do_push = 1'b1;
								mode_d  = MODE_INSIDE;
							end else begin
								do_pass = 1'b1;
							end
						end
						MODE_INSIDE: begin
							do_push = 1'b1;
							if (sts.is_end) begin
								do_flush = 1'b1;
								mode_d   = MODE_AFTER;
							end
						end
						default: do_pass = 1'b1;
					endcase
					// end of sequence: anything still held goes out reversed
					if (is_last_input) begin
						mode_d = MODE_BEFORE;
						if (do_push) begin
							do_flush = 1'b1;
						end
					end
					cmd.push        = do_push;
					cmd.load_pass   = do_pass;
					cmd.flush_start = do_flush;
					cmd.out_last    = is_last_input;
					if (do_flush) begin
						seq_last_d = is_last_input;
						state_d    = ST_POP_RD;
					end
				end
			end
			ST_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = ST_POP_WR;
			end
			ST_POP_WR: begin
				if (sts.out_free) begin
					cmd.load_pop = 1'b1;
					cmd.out_last = seq_last_q && sts.count_zero;
					state_d      = sts.count_zero ? ST_IDLE : ST_POP_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_last_resets_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_last_input) |=> (mode_q == MODE_BEFORE))
		else $error("mode not back to before-segment after last item");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_pass || cmd.load_pop) |-> sts.out_free)
		else $error("output register loaded while occupied");

	a_flush_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_start |=> (state_q == ST_POP_RD))
		else $error("flush did not start popping");
`endif

endmodule

### sv/stream_segment_reverser_top.sv
// stream segment reverser: one element per input item, the segment from the
// start marker through the end marker comes out in reverse order
// channels:
//   input  in_valid / in_stall carries element_value and is_last_input
//   output out_valid / out_stall carries out_value, is_last_output, overflow
//   config cfg_valid / cfg_ready, cfg_index 0 = start marker, 1 = end marker;
//          cfg_ready is always high, other indexes are ignored
// timing:
//   a pass-through item shows on the output register in the cycle after it is
//   accepted; one item per cycle is accepted while the output drains
//   an element held on the stack takes no output slot when accepted
//   a flush pops each held element by a read of the stack memory's registered
//   port, then a load of the output register, and stalls the input
// reset clears the markers to zero, empties the stack and returns to the
// before-segment mode; a stalled output holds its item, and the input then
// stalls until the output register can take the next result
// depends on ssr_pkg, ssr_ctrl, ssr_datapath
module stream_segment_reverser_top import ssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] element_value,
	input  logic                  is_last_input,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic                  is_last_output,
	output logic                  overflow
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	ssr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.is_last_input (is_last_input),
		.sts           (sts),
		.cmd           (cmd)
	);

	ssr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.element_value  (element_value),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_value      (out_value),
		.is_last_output (is_last_output),
		.overflow       (overflow)
	);

endmodule
